[rtl/tpcd_pkg.sv]
package tpcd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int OUT_IDX_W = 32;
    localparam int CFG_W = 32;

    // register map of the configuration port
    typedef enum logic [1:0] {
        CFG_LEVEL_THRESHOLD = 2'd0,
        CFG_MERGE_GAP       = 2'd1,
        CFG_SKIP_PREFIX     = 2'd2,
        CFG_MIN_WIDTH       = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] level_threshold;
        logic [CFG_W-1:0]           merge_gap;
        logic [CFG_W-1:0]           skip_prefix;
        logic [CFG_W-1:0]           min_width;
    } cfg_t;

    typedef struct packed {
        logic                       cluster_valid;
        logic [OUT_IDX_W-1:0]       start_index;
        logic [OUT_IDX_W-1:0]       end_index;
        logic [OUT_IDX_W-1:0]       peak_index;
        logic signed [SAMPLE_W-1:0] peak_value;
        logic                       last_result;
    } res_t;

endpackage

[rtl/tpcd_if.sv]
interface tpcd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tpcd_pkg::SAMPLE_W-1:0] sample;
    logic                                 last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface tpcd_result_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  cluster_valid;
    logic [tpcd_pkg::OUT_IDX_W-1:0]        start_index;
    logic [tpcd_pkg::OUT_IDX_W-1:0]        end_index;
    logic [tpcd_pkg::OUT_IDX_W-1:0]        peak_index;
    logic signed [tpcd_pkg::SAMPLE_W-1:0]  peak_value;
    logic                                  last_result;

    modport source (output valid, output cluster_valid, output start_index,
                    output end_index, output peak_index, output peak_value,
                    output last_result, input ready);
    modport sink (input valid, input cluster_valid, input start_index,
                  input end_index, input peak_index, input peak_value,
                  input last_result, output ready);
endinterface

interface tpcd_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  index;
    logic [tpcd_pkg::CFG_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/threshold_peak_cluster_detector.sv]
// Threshold peak detector with cluster merging. Samples stream in one per
// cycle on "samples"; the front stage numbers each sample, checks it against
// skip_prefix and level_threshold, and drops the classified sample into a
// two-entry queue. The back stage pops one queued sample per cycle, updates
// the open run and the pending cluster, and writes zero, one or two results
// into a four-entry result buffer drained on "results". Sustained rate is one
// sample per cycle; a sample is taken by the back stage only while the result
// buffer has two free entries, so a stalled result sink backs up into the
// queue and then into "samples". A sample passes through the queue and is
// then popped into the registered result buffer before the result it causes
// is offered on "results". The end of a signal always yields a result with
// last_result set: the flushed cluster, or an empty end marker.
// Configuration writes are always accepted (cfg.ready tied high) and take
// effect on the next cycle; write them only while the block is idle.
module threshold_peak_cluster_detector #(
    parameter int INDEX_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tpcd_cfg_if.sink             cfg,
    tpcd_sample_if.sink          samples,
    tpcd_result_if.source        results
);

    localparam int EVT_W = 2 * INDEX_BITS + tpcd_pkg::SAMPLE_W + 3;

    tpcd_pkg::cfg_t   cfg_reg, cfg_next;
    logic             fe_valid, fe_ready;
    logic [EVT_W-1:0] fe_bits;
    logic             be_valid, be_ready;
    logic [EVT_W-1:0] be_bits;
    tpcd_pkg::res_t   res;

    // config registers
    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (tpcd_pkg::cfg_idx_t'(cfg.index))
                tpcd_pkg::CFG_LEVEL_THRESHOLD: cfg_next.level_threshold = cfg.data[15:0];
                tpcd_pkg::CFG_MERGE_GAP:       cfg_next.merge_gap       = cfg.data;
                tpcd_pkg::CFG_SKIP_PREFIX:     cfg_next.skip_prefix     = cfg.data;
                tpcd_pkg::CFG_MIN_WIDTH:       cfg_next.min_width       = cfg.data;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: index and classify
    tpcd_front #(
        .INDEX_BITS (INDEX_BITS),
        .EVT_W      (EVT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .in_sample (samples.sample),
        .in_last   (samples.last_sample),
        .evt_valid (fe_valid),
        .evt_ready (fe_ready),
        .evt_bits  (fe_bits)
    );

    // decoupling queue between the two stages
    tpcd_fifo #(
        .WIDTH (EVT_W),
        .AW    (1)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_bits),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (be_bits)
    );

    // back: run tracking, merge, emit
    tpcd_back #(
        .INDEX_BITS (INDEX_BITS),
        .EVT_W      (EVT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .evt_valid (be_valid),
        .evt_ready (be_ready),
        .evt_bits  (be_bits),
        .res_valid (results.valid),
        .res_ready (results.ready),
        .res       (res)
    );

    assign results.cluster_valid = res.cluster_valid;
    assign results.start_index   = res.start_index;
    assign results.end_index     = res.end_index;
    assign results.peak_index    = res.peak_index;
    assign results.peak_value    = res.peak_value;
    assign results.last_result   = res.last_result;

endmodule

[rtl/tpcd_fifo.sv]
module tpcd_fifo #(
    parameter int WIDTH = 8,
    parameter int AW = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/tpcd_front.sv]
module tpcd_front #(
    parameter int INDEX_BITS = 32,
    parameter int EVT_W = 2 * INDEX_BITS + tpcd_pkg::SAMPLE_W + 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tpcd_pkg::cfg_t                       cfg,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [tpcd_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                                 in_last,
    output logic                                 evt_valid,
    input  logic                                 evt_ready,
    output logic [EVT_W-1:0]                     evt_bits
);

    localparam int CW = (INDEX_BITS > tpcd_pkg::CFG_W) ? INDEX_BITS : tpcd_pkg::CFG_W;

    typedef struct packed {
        logic [INDEX_BITS-1:0]                idx;
        logic [INDEX_BITS-1:0]                idx_next;
        logic signed [tpcd_pkg::SAMPLE_W-1:0] sample;
        logic                                 active;
        logic                                 above;
        logic                                 last;
    } evt_t;

    logic [INDEX_BITS-1:0] count_reg, count_next;
    logic                  accept;
    evt_t                  evt;

    assign in_ready  = evt_ready;
    assign evt_valid = in_valid;
    assign accept    = in_valid && in_ready;
    assign evt_bits  = evt;

    // classify: past the skipped prefix, strictly above threshold
    always_comb
    begin
        evt.idx      = count_reg;
        evt.idx_next = count_reg + 1'b1;
        evt.sample   = in_sample;
        evt.active   = (CW'(count_reg) >= CW'(cfg.skip_prefix));
        evt.above    = ($signed(in_sample) > $signed(cfg.level_threshold));
        evt.last     = in_last;
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = in_last ? '0 : evt.idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/tpcd_back.sv]
module tpcd_back #(
    parameter int INDEX_BITS = 32,
    parameter int EVT_W = 2 * INDEX_BITS + tpcd_pkg::SAMPLE_W + 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tpcd_pkg::cfg_t   cfg,
    input  logic             evt_valid,
    output logic             evt_ready,
    input  logic [EVT_W-1:0] evt_bits,
    output logic             res_valid,
    input  logic             res_ready,
    output tpcd_pkg::res_t   res
);

    localparam int CW = (INDEX_BITS > tpcd_pkg::CFG_W) ? INDEX_BITS : tpcd_pkg::CFG_W;
    localparam int OB_AW = 2;
    localparam int OB_DEPTH = 1 << OB_AW;

    typedef struct packed {
        logic [INDEX_BITS-1:0]                idx;
        logic [INDEX_BITS-1:0]                idx_next;
        logic signed [tpcd_pkg::SAMPLE_W-1:0] sample;
        logic                                 active;
        logic                                 above;
        logic                                 last;
    } evt_t;

    evt_t evt;

    // run and pending-cluster state
    logic                                 in_peak_reg, in_peak_next;
    logic [INDEX_BITS-1:0]                run_start_reg, run_start_next;
    logic signed [tpcd_pkg::SAMPLE_W-1:0] run_max_reg, run_max_next;
    logic [INDEX_BITS-1:0]                run_arg_reg, run_arg_next;
    logic                                 pend_valid_reg, pend_valid_next;
    logic [INDEX_BITS-1:0]                pend_start_reg, pend_start_next;
    logic [INDEX_BITS-1:0]                pend_end_reg, pend_end_next;
    logic [INDEX_BITS-1:0]                pend_arg_reg, pend_arg_next;
    logic signed [tpcd_pkg::SAMPLE_W-1:0] pend_max_reg, pend_max_next;

    // result buffer
    tpcd_pkg::res_t  obuf [OB_DEPTH];
    logic [OB_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OB_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OB_AW:0]   cnt_reg, cnt_next;

    logic                                 take, grow, upd, close_now, close_last, fin, keep;
    logic                                 mergeable, take_max, emit0;
    logic [INDEX_BITS-1:0]                rs, ra, fin_end, width, gap;
    logic signed [tpcd_pkg::SAMPLE_W-1:0] rm;
    logic                                 p_v;
    logic [INDEX_BITS-1:0]                p_s, p_e, p_a;
    logic signed [tpcd_pkg::SAMPLE_W-1:0] p_m;
    tpcd_pkg::res_t                       r0, r1, first_res;
    logic [1:0]                           push_n;
    logic                                 do_pop;

    assign evt       = evt_bits;
    // room for the two results one sample can cause
    assign evt_ready = (cnt_reg <= (OB_AW+1)'(OB_DEPTH - 2));
    assign take      = evt_valid && evt_ready;
    assign res_valid = (cnt_reg != '0);
    assign res       = obuf[rd_ptr_reg];
    assign do_pop    = res_valid && res_ready;

    always_comb
    begin
        // extend the open run by this sample; later sample wins on ties
        grow = evt.active && evt.above;
        upd  = grow && (!in_peak_reg || (evt.sample >= run_max_reg));
        rs   = (grow && !in_peak_reg) ? evt.idx : run_start_reg;
        rm   = upd ? evt.sample : run_max_reg;
        ra   = upd ? evt.idx : run_arg_reg;

        close_now  = evt.active && !evt.above && in_peak_reg;
        close_last = evt.last && (in_peak_reg || grow);
        fin        = close_now || close_last;
        fin_end    = close_now ? evt.idx : evt.idx_next;

        width     = fin_end - rs;
        gap       = rs - pend_end_reg;
        keep      = fin && (CW'(width) >= CW'(cfg.min_width));
        mergeable = pend_valid_reg && (CW'(gap) <= CW'(cfg.merge_gap));
        take_max  = (rm >= pend_max_reg);

        p_v   = pend_valid_reg;
        p_s   = pend_start_reg;
        p_e   = pend_end_reg;
        p_a   = pend_arg_reg;
        p_m   = pend_max_reg;
        emit0 = 1'b0;
        if (keep)
        begin
            if (mergeable)
            begin
                p_e = fin_end;
                if (take_max)
                begin
                    p_m = rm;
                    p_a = ra;
                end
            end
            else
            begin
                emit0 = pend_valid_reg;
                p_v   = 1'b1;
                p_s   = rs;
                p_e   = fin_end;
                p_a   = ra;
                p_m   = rm;
            end
        end

        // pushed-out cluster
        r0.cluster_valid = 1'b1;
        r0.start_index   = tpcd_pkg::OUT_IDX_W'(pend_start_reg);
        r0.end_index     = tpcd_pkg::OUT_IDX_W'(pend_end_reg);
        r0.peak_index    = tpcd_pkg::OUT_IDX_W'(pend_arg_reg);
        r0.peak_value    = pend_max_reg;
        r0.last_result   = 1'b0;

        // final result: flushed cluster or empty end marker
        r1.cluster_valid = p_v;
        r1.start_index   = p_v ? tpcd_pkg::OUT_IDX_W'(p_s) : '0;
        r1.end_index     = p_v ? tpcd_pkg::OUT_IDX_W'(p_e) : '0;
        r1.peak_index    = p_v ? tpcd_pkg::OUT_IDX_W'(p_a) : '0;
        r1.peak_value    = p_v ? p_m : '0;
        r1.last_result   = 1'b1;

        first_res = emit0 ? r0 : r1;
        push_n    = take ? (2'(emit0) + 2'(evt.last)) : 2'd0;
    end

    always_comb
    begin
        in_peak_next    = in_peak_reg;
        run_start_next  = run_start_reg;
        run_max_next    = run_max_reg;
        run_arg_next    = run_arg_reg;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        pend_arg_next   = pend_arg_reg;
        pend_max_next   = pend_max_reg;
        if (take)
        begin
            run_start_next  = rs;
            run_max_next    = rm;
            run_arg_next    = ra;
            pend_start_next = p_s;
            pend_end_next   = p_e;
            pend_arg_next   = p_a;
            pend_max_next   = p_m;
            if (evt.last)
            begin
                in_peak_next    = 1'b0;
                pend_valid_next = 1'b0;
            end
            else
            begin
                in_peak_next    = fin ? 1'b0 : (in_peak_reg || grow);
                pend_valid_next = p_v;
            end
        end

        wr_ptr_next = wr_ptr_reg + OB_AW'(push_n);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (OB_AW+1)'(push_n) - (OB_AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_peak_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            in_peak_reg    <= in_peak_next;
            pend_valid_reg <= pend_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_start_reg  <= run_start_next;
        run_max_reg    <= run_max_next;
        run_arg_reg    <= run_arg_next;
        pend_start_reg <= pend_start_next;
        pend_end_reg   <= pend_end_next;
        pend_arg_reg   <= pend_arg_next;
        pend_max_reg   <= pend_max_next;
        if (push_n != 2'd0)
        begin
            obuf[wr_ptr_reg] <= first_res;
        end
        if (push_n == 2'd2)
        begin
            obuf[wr_ptr_reg + 1'b1] <= r1;
        end
    end

endmodule

[rtl/tpcd_checker.sv]
module tpcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        res_valid,
    input logic        res_ready,
    input logic        res_cluster_valid,
    input logic [31:0] res_start,
    input logic [31:0] res_end,
    input logic [31:0] res_peak_index,
    input logic [15:0] res_peak_value,
    input logic        res_last
);

    // a stalled result stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    // the empty end marker is all zero and closes the signal
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_cluster_valid |-> res_last && (res_start == '0) &&
        (res_end == '0) && (res_peak_index == '0) && (res_peak_value == '0))
        else $error("malformed end marker");

    // nothing is offered coming out of reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result offered during reset");

    // config writes never stall
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind threshold_peak_cluster_detector tpcd_checker u_tpcd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .res_valid         (results.valid),
    .res_ready         (results.ready),
    .res_cluster_valid (results.cluster_valid),
    .res_start         (results.start_index),
    .res_end           (results.end_index),
    .res_peak_index    (results.peak_index),
    .res_peak_value    (results.peak_value),
    .res_last          (results.last_result)
);
